FILE: rtl/core/uptx_pkg.sv
package uptx_pkg;

  localparam int CMD_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 9;
  localparam int STATUS_W  = 2;
  localparam int PACE_W    = 8;
  localparam int PAUSE_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;

  localparam logic [PACE_W-1:0]  PACE_RST    = 8'd10;
  localparam logic [PAUSE_W-1:0] PAUSE_RST   = 7'd100;
  localparam logic [PACE_W-1:0]  ELAPSED_MAX = 8'hff;

  localparam int OUTQ_DEPTH = 3;
  localparam int OUTQ_IDX_W = 2;
  localparam int OUTQ_CNT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_HEADER = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_SEND   = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ADMIT_NONE   = 2'd0,
    ADMIT_OK     = 2'd1,
    ADMIT_REJECT = 2'd2
  } admit_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PACE_TIMEOUT = 2'd0,
    REG_WRAP_PAUSE   = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic   tx_valid;
    admit_e status;
  } ctrl_res_t;

endpackage

FILE: rtl/core/uptx_ring.sv
module uptx_ring #(
  parameter int DEPTH = 256
) (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]       wr_addr_i,
  input  logic [uptx_pkg::BYTE_W-1:0]    wr_data_i,
  input  logic                           rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]       rd_addr_i,
  output logic [uptx_pkg::BYTE_W-1:0]    rd_data_o
);
  import uptx_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/uptx_ctrl.sv
module uptx_ctrl #(
  parameter int DEPTH = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [uptx_pkg::CMD_W-1:0]        command_i,
  input  logic [uptx_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic [uptx_pkg::LEN_W-1:0]        packet_length_i,
  input  logic                              tx_done_i,
  input  logic                              cfg_we_i,
  input  logic [uptx_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [uptx_pkg::CFG_W-1:0]        cfg_data_i,
  output logic                              wr_en_o,
  output logic [$clog2(DEPTH)-1:0]          wr_addr_o,
  output logic [uptx_pkg::BYTE_W-1:0]       wr_data_o,
  output logic                              rd_en_o,
  output logic [$clog2(DEPTH)-1:0]          rd_addr_o,
  output uptx_pkg::ctrl_res_t               res_o,
  output logic [$clog2(DEPTH+1)-1:0]        fill_o
);
  import uptx_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 2;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);

  logic [PTR_W-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0]   occ_q, occ_d, res_q, res_d;
  logic [LEN_W-1:0]   disc_q, disc_d;
  logic [PACE_W-1:0]  elapsed_q, elapsed_d, pace_q;
  logic [PAUSE_W-1:0] pause_q, pause_d, wrap_q;
  logic [PTR_W-1:0]   rp_inc;
  logic [SUM_W-1:0]   need;
  logic               fire;
  cmd_e               cmd;
  ctrl_res_t          res;

  assign cmd    = cmd_e'(command_i);
  assign rp_inc = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
  assign need   = SUM_W'(occ_q) + SUM_W'(packet_length_i);
  assign fire   = (occ_q != '0) && (pause_q == '0) && (tx_done_i || (elapsed_q > pace_q));

  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    occ_d     = occ_q;
    res_d     = res_q;
    disc_d    = disc_q;
    elapsed_d = elapsed_q;
    pause_d   = pause_q;
    wr_en_o   = 1'b0;
    rd_en_o   = 1'b0;
    res       = '{tx_valid: 1'b0, status: ADMIT_NONE};
    case (cmd)
      CMD_HEADER: begin
        if ((packet_length_i == '0) || (need > DEPTH_S)) begin
          res.status = ADMIT_REJECT;
          res_d      = '0;
          disc_d     = packet_length_i;
        end else begin
          res.status = ADMIT_OK;
          res_d      = CNT_W'(packet_length_i);
          disc_d     = '0;
        end
      end
      CMD_DATA: begin
        if (res_q != '0) begin
          wr_en_o = accept_i;
          wp_d    = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
          occ_d   = occ_q + 1'b1;
          res_d   = res_q - 1'b1;
        end else if (disc_q != '0) begin
          disc_d = disc_q - 1'b1;
        end
      end
      CMD_SEND: begin
        if (fire) begin
          res.tx_valid = 1'b1;
          rd_en_o      = accept_i;
          rp_d         = rp_inc;
          occ_d        = occ_q - 1'b1;
          elapsed_d    = '0;
          if (rp_inc == '0) begin
            pause_d = wrap_q;
          end
        end
      end
      default: begin
        if (elapsed_q != ELAPSED_MAX) begin
          elapsed_d = elapsed_q + 1'b1;
        end
        if (pause_q != '0) begin
          pause_d = pause_q - 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      rp_q      <= '0;
      occ_q     <= '0;
      res_q     <= '0;
      disc_q    <= '0;
      elapsed_q <= '0;
      pause_q   <= '0;
    end else if (accept_i) begin
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      occ_q     <= occ_d;
      res_q     <= res_d;
      disc_q    <= disc_d;
      elapsed_q <= elapsed_d;
      pause_q   <= pause_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pace_q <= PACE_RST;
      wrap_q <= PAUSE_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_PACE_TIMEOUT) begin
        pace_q <= cfg_data_i[PACE_W-1:0];
      end else if (cfg_index_i == REG_WRAP_PAUSE) begin
        wrap_q <= cfg_data_i[PAUSE_W-1:0];
      end
    end
  end

  assign wr_addr_o = wp_q;
  assign wr_data_o = data_byte_i;
  assign rd_addr_o = rp_q;
  assign res_o     = res;
  assign fill_o    = occ_d;

endmodule

FILE: rtl/core/uptx_outq.sv
module uptx_outq #(
  parameter int FILL_W = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  uptx_pkg::ctrl_res_t           res_i,
  input  logic [FILL_W-1:0]             fill_i,
  input  logic [uptx_pkg::BYTE_W-1:0]   rd_data_i,
  input  logic                          pop_i,
  output logic                          full_o,
  output logic                          valid_o,
  output logic                          tx_valid_o,
  output logic [uptx_pkg::BYTE_W-1:0]   tx_byte_o,
  output logic [uptx_pkg::STATUS_W-1:0] status_o,
  output logic [FILL_W-1:0]             fill_o
);
  import uptx_pkg::*;

  localparam logic [OUTQ_IDX_W-1:0] IDX_LAST = OUTQ_IDX_W'(OUTQ_DEPTH - 1);
  localparam logic [OUTQ_CNT_W:0]   CAP      = (OUTQ_CNT_W + 1)'(OUTQ_DEPTH);

  logic                  a_valid_q;
  ctrl_res_t             a_res_q;
  logic [FILL_W-1:0]     a_fill_q;

  ctrl_res_t             q_res  [OUTQ_DEPTH];
  logic [FILL_W-1:0]     q_fill [OUTQ_DEPTH];
  logic [BYTE_W-1:0]     q_byte [OUTQ_DEPTH];
  logic [OUTQ_IDX_W-1:0] head_q, tail_q;
  logic [OUTQ_CNT_W-1:0] cnt_q;
  logic                  do_pop;

  assign do_pop = pop_i && (cnt_q != '0);
  assign full_o = ((OUTQ_CNT_W + 1)'(cnt_q) + (OUTQ_CNT_W + 1)'(a_valid_q)) >= CAP;

  // stage a lines up the request with the registered ring read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      a_res_q  <= res_i;
      a_fill_q <= fill_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      q_res[tail_q]  <= a_res_q;
      q_fill[tail_q] <= a_fill_q;
      q_byte[tail_q] <= a_res_q.tx_valid ? rd_data_i : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (a_valid_q) begin
        tail_q <= (tail_q == IDX_LAST) ? '0 : tail_q + 1'b1;
      end
      if (do_pop) begin
        head_q <= (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
      end
      if (a_valid_q && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!a_valid_q && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign valid_o    = (cnt_q != '0);
  assign tx_valid_o = q_res[head_q].tx_valid;
  assign tx_byte_o  = q_byte[head_q];
  assign status_o   = q_res[head_q].status;
  assign fill_o     = q_fill[head_q];

endmodule

FILE: rtl/core/paced_uart_tx_ring_buffer.sv
// paced uart transmit ring buffer
// input channel: in_valid_i / in_stall_o with command_i, data_byte_i,
//   packet_length_i and tx_done_i; a request is taken when valid is high
//   and stall is low
// output channel: out_valid_o / out_stall_i with tx_valid_o, tx_byte_o,
//   admit_status_o and fill_level_o; every request gives exactly one result
// config channel: cfg_valid_i / cfg_ready_o, cfg_index_i selects
//   pace timeout (0) or wrap pause (1); ready is always high
// a result is registered in the ring read register and then in the result
//   queue before it shows on the output
// throughput: one request per cycle while in_stall_o is low, set by the pointer
//   and counter update and the one write and one read port of the ring
// the ring needs no clearing pass, only counted entries are ever read
// reset clears pointers, counters and the result queue and loads the
//   register defaults (timeout 10, pause 100)
// when the receiver stalls, up to three results wait in the result queue;
//   in_stall_o rises once queue and read stage together hold three results
module paced_uart_tx_ring_buffer #(
  parameter int DEPTH = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [uptx_pkg::CMD_W-1:0]        command_i,
  input  logic [uptx_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic [uptx_pkg::LEN_W-1:0]        packet_length_i,
  input  logic                              tx_done_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              tx_valid_o,
  output logic [uptx_pkg::BYTE_W-1:0]       tx_byte_o,
  output logic [uptx_pkg::STATUS_W-1:0]     admit_status_o,
  output logic [$clog2(DEPTH+1)-1:0]        fill_level_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [uptx_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [uptx_pkg::CFG_W-1:0]        cfg_data_i
);
  import uptx_pkg::*;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic              accept;
  logic              full;
  logic              wr_en, rd_en;
  logic [PTR_W-1:0]  wr_addr, rd_addr;
  logic [BYTE_W-1:0] wr_data, rd_data;
  ctrl_res_t         res;
  logic [FILL_W-1:0] fill;

  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;
  assign cfg_ready_o = 1'b1;

  uptx_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .accept_i        (accept),
    .command_i,
    .data_byte_i,
    .packet_length_i,
    .tx_done_i,
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .res_o           (res),
    .fill_o          (fill)
  );

  uptx_ring #(
    .DEPTH(DEPTH)
  ) u_ring (
    .clk_i,
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  uptx_outq #(
    .FILL_W(FILL_W)
  ) u_outq (
    .clk_i,
    .rst_ni,
    .push_i     (accept),
    .res_i      (res),
    .fill_i     (fill),
    .rd_data_i  (rd_data),
    .pop_i      (!out_stall_i),
    .full_o     (full),
    .valid_o    (out_valid_o),
    .tx_valid_o (tx_valid_o),
    .tx_byte_o  (tx_byte_o),
    .status_o   (admit_status_o),
    .fill_o     (fill_level_o)
  );

endmodule

FILE: rtl/core/uptx_checker.sv
module uptx_checker #(
  parameter int DEPTH = 256
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          tx_valid_o,
  input logic [uptx_pkg::BYTE_W-1:0]   tx_byte_o,
  input logic [uptx_pkg::STATUS_W-1:0] admit_status_o,
  input logic [$clog2(DEPTH+1)-1:0]    fill_level_o
);
  import uptx_pkg::*;

  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

  // a waiting result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // fill level stays within the ring
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fill_level_o <= FILL_MAX)
    else $error("fill level beyond ring depth");

  // no byte without a send
  a_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_valid_o |-> tx_byte_o == '0)
    else $error("byte shown without send");

  // a header result never sends
  a_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (admit_status_o != ADMIT_NONE) |-> !tx_valid_o)
    else $error("send on header result");

endmodule

bind paced_uart_tx_ring_buffer uptx_checker #(
  .DEPTH(DEPTH)
) u_uptx_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .tx_valid_o     (tx_valid_o),
  .tx_byte_o      (tx_byte_o),
  .admit_status_o (admit_status_o),
  .fill_level_o   (fill_level_o)
);

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import uptx_pkg::*;

  localparam int DEPTH      = 256;
  localparam int FILL_W     = $clog2(DEPTH + 1);
  localparam int HOLD_LEN   = 400;
  localparam int CYCLE_CAP  = 400000;
  localparam int PHASES     = 6;
  localparam int PHASE_REQS = 138;

  typedef struct packed {
    cmd_e              cmd;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              done;
  } ring_req_t;

  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    admit_e            status;
    logic [FILL_W-1:0] fill;
  } ring_res_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_e;

  logic                 clk_i;
  logic                 rst_ni          = 1'b0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     command_i       = '0;
  logic [BYTE_W-1:0]    data_byte_i     = '0;
  logic [LEN_W-1:0]     packet_length_i = '0;
  logic                 tx_done_i       = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic                 tx_valid_o;
  logic [BYTE_W-1:0]    tx_byte_o;
  logic [STATUS_W-1:0]  admit_status_o;
  logic [FILL_W-1:0]    fill_level_o;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i     = REG_PACE_TIMEOUT;
  logic [CFG_W-1:0]     cfg_data_i      = '0;

  paced_uart_tx_ring_buffer #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .data_byte_i    (data_byte_i),
    .packet_length_i(packet_length_i),
    .tx_done_i      (tx_done_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .tx_valid_o     (tx_valid_o),
    .tx_byte_o      (tx_byte_o),
    .admit_status_o (admit_status_o),
    .fill_level_o   (fill_level_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // predicted ring state
  logic [BYTE_W-1:0]  ring_mem [DEPTH];
  logic [7:0]         wr_ptr       = '0;
  logic [7:0]         rd_ptr       = '0;
  logic [FILL_W-1:0]  fill_cnt     = '0;
  logic [LEN_W-1:0]   reserve_left = '0;
  logic [LEN_W-1:0]   discard_left = '0;
  logic [PACE_W-1:0]  elapsed_cnt  = '0;
  logic [PAUSE_W-1:0] pause_left   = '0;
  logic [PACE_W-1:0]  pace_cfg     = PACE_RST;
  logic [PAUSE_W-1:0] pause_cfg    = PAUSE_RST;

  ring_req_t pending_reqs [$];
  ring_res_t expected_results [$];
  ring_req_t next_req;

  int       mismatch_cnt = 0;
  int       cyc_cnt      = 0;
  logic     in_taken     = 1'b0;
  int       burst_left   = 0;
  int       gap_left     = 0;
  int       hold_req     = 0;
  int       hold_ack     = 0;
  int       hold_left    = 0;
  rx_mode_e rx_mode      = RX_FREE;
  int       rx_mode_left = 0;

  function automatic ring_res_t predict_ring_step(ring_req_t r);
    ring_res_t res;
    res = '0;
    res.status = ADMIT_NONE;
    case (r.cmd)
      CMD_HEADER: begin
        reserve_left = '0;
        discard_left = '0;
        if (r.len == '0 || int'(fill_cnt) + int'(r.len) > DEPTH) begin
          res.status = ADMIT_REJECT;
          discard_left = r.len;
        end else begin
          res.status = ADMIT_OK;
          reserve_left = r.len;
        end
      end
      CMD_DATA: begin
        if (reserve_left != '0) begin
          ring_mem[wr_ptr] = r.data;
          wr_ptr = wr_ptr + 8'd1;
          fill_cnt = fill_cnt + 1'b1;
          reserve_left = reserve_left - 1'b1;
        end else if (discard_left != '0) begin
          discard_left = discard_left - 1'b1;
        end
      end
      CMD_SEND: begin
        if (fill_cnt != '0 && pause_left == '0 && (r.done || elapsed_cnt > pace_cfg)) begin
          res.tx_valid = 1'b1;
          res.tx_byte = ring_mem[rd_ptr];
          rd_ptr = rd_ptr + 8'd1;
          fill_cnt = fill_cnt - 1'b1;
          elapsed_cnt = '0;
          if (rd_ptr == 8'd0) pause_left = pause_cfg;
        end
      end
      default: begin
        if (elapsed_cnt != ELAPSED_MAX) elapsed_cnt = elapsed_cnt + 1'b1;
        if (pause_left != '0) pause_left = pause_left - 1'b1;
      end
    endcase
    res.fill = fill_cnt;
    return res;
  endfunction

  task automatic flag_error(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic push_req(cmd_e c, int d, int l, int t);
    ring_req_t r;
    r.cmd  = c;
    r.data = d[BYTE_W-1:0];
    r.len  = l[LEN_W-1:0];
    r.done = t[0];
    pending_reqs.push_back(r);
  endtask

  task automatic push_side_req();
    if ($urandom_range(0, 2) == 0) push_req(CMD_TICK, $urandom_range(0, 255),
                                            $urandom_range(0, 511), $urandom_range(0, 1));
    else push_req(CMD_SEND, $urandom_range(0, 255), $urandom_range(0, 511),
                  $urandom_range(0, 1));
  endtask

  task automatic gen_random(int n);
    int made;
    int pick;
    int len;
    int nbytes;
    int run;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // packet: header then its bytes, with sends and ticks mixed in
        run = $urandom_range(0, 99);
        if (run < 4) len = 0;
        else if (run < 9) len = $urandom_range(257, 511);
        else if (run < 17) len = $urandom_range(17, 256);
        else len = $urandom_range(1, 16);
        push_req(CMD_HEADER, $urandom_range(0, 255), len, $urandom_range(0, 1));
        made++;
        nbytes = len;
        run = $urandom_range(0, 9);
        if (run == 0) nbytes = $urandom_range(0, len);
        else if (run == 1) nbytes = len + $urandom_range(1, 3);
        if (len > DEPTH) nbytes = $urandom_range(0, 6);
        repeat (nbytes) begin
          push_req(CMD_DATA, $urandom_range(0, 255), $urandom_range(0, 511),
                   $urandom_range(0, 1));
          made++;
          if ($urandom_range(0, 4) == 0) begin
            push_side_req();
            made++;
          end
        end
      end else if (pick < 75) begin
        run = $urandom_range(1, 6);
        repeat (run) push_req(CMD_SEND, $urandom_range(0, 255), $urandom_range(0, 511),
                              ($urandom_range(0, 4) != 0));
        made += run;
      end else if (pick < 92) begin
        run = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 140) : $urandom_range(1, 8);
        repeat (run) push_req(CMD_TICK, $urandom_range(0, 255), $urandom_range(0, 511),
                              $urandom_range(0, 1));
        made += run;
      end else begin
        push_req(cmd_e'($urandom_range(0, 3)), $urandom_range(0, 255),
                 $urandom_range(0, 511), $urandom_range(0, 1));
        made++;
      end
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_PACE_TIMEOUT: pace_cfg = val;
      REG_WRAP_PAUSE:   pause_cfg = val[PAUSE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        command_i       <= next_req.cmd;
        data_byte_i     <= next_req.data;
        packet_length_i <= next_req.len;
        tx_done_i       <= next_req.done;
        in_valid_i      <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver stall pattern
  always @(negedge clk_i) begin
    if (hold_ack != hold_req) begin
      hold_ack = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(16, 96);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_FREE:  out_stall_i <= 1'b0;
        RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:  out_stall_i <= (cyc_cnt % 7 < 3);
      endcase
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin : monitor
    ring_res_t got;
    ring_res_t want;
    ring_req_t req;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.tx_valid = tx_valid_o;
        got.tx_byte  = tx_byte_o;
        got.status   = admit_e'(admit_status_o);
        got.fill     = fill_level_o;
        if (expected_results.size() == 0) begin
          flag_error($sformatf("unexpected result valid=%0b byte=%02h status=%0d fill=%0d",
                               got.tx_valid, got.tx_byte, got.status, got.fill));
        end else begin
          want = expected_results.pop_front();
          if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
              got.status !== want.status || got.fill !== want.fill)
            flag_error({
              $sformatf("exp valid=%0b byte=%02h status=%0d fill=%0d",
                        want.tx_valid, want.tx_byte, want.status, want.fill),
              $sformatf(", got valid=%0b byte=%02h status=%0d fill=%0d",
                        got.tx_valid, got.tx_byte, got.status, got.fill)});
        end
      end
      if (in_valid_i && !in_stall_o) begin
        in_taken = 1'b1;
        req.cmd  = cmd_e'(command_i);
        req.data = data_byte_i;
        req.len  = packet_length_i;
        req.done = tx_done_i;
        expected_results.push_back(predict_ring_step(req));
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty poll, stray byte, rejects, release on new header, pacing
    push_req(CMD_SEND, 8'h00, 0, 1);
    push_req(CMD_DATA, 8'h5a, 0, 0);
    push_req(CMD_HEADER, 8'h00, 0, 0);
    push_req(CMD_HEADER, 8'hff, 511, 1);
    push_req(CMD_DATA, 8'hff, 511, 1);
    push_req(CMD_HEADER, 8'h00, 257, 0);
    push_req(CMD_HEADER, 8'h00, 256, 0);
    push_req(CMD_DATA, 8'h00, 0, 0);
    push_req(CMD_DATA, 8'hff, 0, 0);
    push_req(CMD_HEADER, 8'h00, 3, 0);
    push_req(CMD_DATA, 8'h81, 0, 0);
    push_req(CMD_SEND, 8'h00, 0, 0);
    push_req(CMD_SEND, 8'h00, 0, 1);
    repeat (11) push_req(CMD_TICK, 8'h00, 0, 0);
    push_req(CMD_SEND, 8'h00, 0, 0);
    push_req(CMD_SEND, 8'h00, 0, 0);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        case (ph)
          1: begin
            write_reg(REG_PACE_TIMEOUT, 8'd0);
            write_reg(REG_WRAP_PAUSE, 8'd0);
          end
          2: begin
            write_reg(REG_PACE_TIMEOUT, 8'd254);
            write_reg(REG_WRAP_PAUSE, 8'd127);
          end
          3: begin
            write_reg(REG_PACE_TIMEOUT, 8'd5);
            write_reg(REG_WRAP_PAUSE, 8'd1);
          end
          4: begin
            write_reg(REG_PACE_TIMEOUT, 8'd20);
            write_reg(REG_WRAP_PAUSE, 8'd30);
          end
          default: begin
            write_reg(REG_PACE_TIMEOUT, 8'd1);
            write_reg(REG_WRAP_PAUSE, 8'd64);
          end
        endcase
      end
      // long receiver hold while requests keep coming
      if (ph == 2) hold_req++;
      gen_random(PHASE_REQS);
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: paced_uart_tx_ring_buffer.f
rtl/core/uptx_pkg.sv
rtl/core/uptx_ring.sv
rtl/core/uptx_ctrl.sv
rtl/core/uptx_outq.sv
rtl/core/paced_uart_tx_ring_buffer.sv
rtl/core/uptx_checker.sv
test/tb.sv
